>>> design/ac_power_meter_unit_macros.svh
// Assertion macros shared by the checker of the AC power meter.
`ifndef AC_POWER_METER_UNIT_MACROS_SVH
`define AC_POWER_METER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define APM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define APM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/apm_pkg.sv
// Shared types, constants and saturation function of the AC power meter.
package apm_pkg;

    localparam int DATA_W          = 32;
    localparam int FRAC_BITS       = 24;
    localparam int PROD_W          = 40;
    localparam int DEF_WINDOW_LEN  = 64;
    localparam int DEF_QUARTER_LEN = 16;

    typedef struct packed {
        logic signed [DATA_W-1:0] volt_sample;
        logic signed [DATA_W-1:0] curr_sample;
        logic signed [DATA_W-1:0] volt_rms;
        logic signed [DATA_W-1:0] curr_rms;
    } sample_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] apparent_power;
        logic signed [DATA_W-1:0] active_power;
        logic signed [DATA_W-1:0] reactive_power;
        logic                     valid_res;
    } result_t;

    // Clamp a wide signed value into the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> design/ac_power_meter_unit.sv
// AC power meter: apparent, active and reactive power from a voltage/current sample stream.
// A sample passes through five register stages: stages 1 to 4 and the output register.
// Throughput: one sample per cycle unless result_ready stalls; each stage's own valid bit lets bubbles collapse.
// The window ring and the quarter-period delay line are single RAMs whose read address
// runs at the next position, which is what lets a sample follow in the very next cycle.
// Reset (rst_n, async, active low) clears control state at once: no clearing pass.
module ac_power_meter_unit #(
    parameter int WINDOW_LEN  = apm_pkg::DEF_WINDOW_LEN,
    parameter int QUARTER_LEN = apm_pkg::DEF_QUARTER_LEN
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  apm_pkg::sample_t sample,
    output logic             result_valid,
    input  logic             result_ready,
    output apm_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data
);

    import apm_pkg::*;

    localparam int LG_WIN = $clog2(WINDOW_LEN);
    localparam int SUM_W  = PROD_W + LG_WIN;
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int DP_W   = (QUARTER_LEN > 1) ? $clog2(QUARTER_LEN) : 1;
    localparam int RING_W = 2 * PROD_W;

    // ------------------------------------------------------------------
    // Configuration: the enable bit. Writes are always taken.
    // ------------------------------------------------------------------
    logic enable_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            enable_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage may load when it is empty or when the
    // stage after it is loading. Disabled samples are taken and dropped.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic s1_free, s2_free, s3_free, s4_free, out_free;
    logic take;

    assign out_free     = !out_valid_reg || result_ready;
    assign s4_free      = !s4_valid_reg || out_free;
    assign s3_free      = !s3_valid_reg || s4_free;
    assign s2_free      = !s2_valid_reg || s3_free;
    assign s1_free      = !s1_valid_reg || s2_free;
    assign sample_ready = s1_free;
    assign take         = sample_valid && sample_ready && enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= sample_valid && enable_reg;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_free)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Quarter-period delay line. The RAM always reads the slot that the
    // next sample will use, so its data is ready at the transfer. Until the
    // line has wrapped once, the delayed voltage reads as zero. With a
    // one-entry line the slot just written is read back through a bypass.
    // ------------------------------------------------------------------
    logic [DP_W-1:0]          dly_pos_reg, dly_pos_next;
    logic                     dly_wrap_reg, dly_byp_reg;
    logic signed [DATA_W-1:0] dly_byp_data_reg;
    logic [DATA_W-1:0]        dly_rd_data;
    logic                     dly_last;
    logic signed [DATA_W-1:0] volt_delayed;

    assign dly_last     = (dly_pos_reg == DP_W'(QUARTER_LEN - 1));
    assign dly_pos_next = !take ? dly_pos_reg : (dly_last ? '0 : dly_pos_reg + 1'b1);

    apm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (QUARTER_LEN)
    ) u_dly_ram (
        .clk     (clk),
        .wr_en   (take),
        .wr_addr (dly_pos_reg),
        .wr_data (sample.volt_sample),
        .rd_addr (dly_pos_next),
        .rd_data (dly_rd_data)
    );

    always_comb
    begin
        if (!dly_wrap_reg)
        begin
            volt_delayed = '0;
        end
        else if (dly_byp_reg)
        begin
            volt_delayed = dly_byp_data_reg;
        end
        else
        begin
            volt_delayed = $signed(dly_rd_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dly_pos_reg  <= '0;
            dly_wrap_reg <= 1'b0;
            dly_byp_reg  <= 1'b0;
        end
        else
        begin
            dly_pos_reg <= dly_pos_next;
            dly_byp_reg <= take && (dly_pos_next == dly_pos_reg);
            if (take && dly_last)
            begin
                dly_wrap_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dly_byp_data_reg <= sample.volt_sample;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register, together with the delayed voltage.
    // ------------------------------------------------------------------
    sample_t                  s1_sample_reg;
    logic signed [DATA_W-1:0] s1_ud_reg;

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_sample_reg <= sample;
            s1_ud_reg     <= volt_delayed;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the three full 64-bit products.
    // ------------------------------------------------------------------
    logic signed [63:0] s2_act_prod_reg, s2_rea_prod_reg, s2_app_prod_reg;

    always_ff @(posedge clk)
    begin
        if (s2_free)
        begin
            s2_act_prod_reg <= s1_sample_reg.volt_sample * s1_sample_reg.curr_sample;
            s2_rea_prod_reg <= s1_ud_reg * s1_sample_reg.curr_sample;
            s2_app_prod_reg <= s1_sample_reg.volt_rms * s1_sample_reg.curr_rms;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: window update. Each product is floored to Q24 (a 40-bit
    // slice), the oldest ring entry leaves the sum and the new one enters.
    // Both rings share one RAM, one position and one fill count since they
    // always move together. Before the ring has filled, the entry leaving
    // is one never written and counts as zero.
    // ------------------------------------------------------------------
    logic                     ring_upd;
    logic [LG_WIN-1:0]        win_pos_reg, win_pos_next;
    logic [FILL_W-1:0]        fill_reg;
    logic                     win_full, win_last, full_after;
    logic [RING_W-1:0]        ring_rd_data;
    logic signed [PROD_W-1:0] act_new, rea_new, act_old, rea_old;
    logic signed [SUM_W-1:0]  act_sum_reg, rea_sum_reg, act_sum_next, rea_sum_next;
    logic signed [DATA_W-1:0] s3_apparent_reg;
    logic                     s3_full_reg;

    assign ring_upd     = s2_valid_reg && s3_free;
    assign win_full     = (fill_reg == FILL_W'(WINDOW_LEN));
    assign win_last     = (win_pos_reg == LG_WIN'(WINDOW_LEN - 1));
    assign win_pos_next = !ring_upd ? win_pos_reg : (win_last ? '0 : win_pos_reg + 1'b1);
    assign full_after   = win_full || (fill_reg == FILL_W'(WINDOW_LEN - 1));

    assign act_new = s2_act_prod_reg[63:FRAC_BITS];
    assign rea_new = s2_rea_prod_reg[63:FRAC_BITS];
    assign act_old = win_full ? $signed(ring_rd_data[RING_W-1:PROD_W]) : '0;
    assign rea_old = win_full ? $signed(ring_rd_data[PROD_W-1:0]) : '0;

    apm_ram #(
        .WIDTH (RING_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (ring_upd),
        .wr_addr (win_pos_reg),
        .wr_data ({act_new, rea_new}),
        .rd_addr (win_pos_next),
        .rd_data (ring_rd_data)
    );

    always_comb
    begin
        act_sum_next = act_sum_reg
                     - {{(SUM_W-PROD_W){act_old[PROD_W-1]}}, act_old}
                     + {{(SUM_W-PROD_W){act_new[PROD_W-1]}}, act_new};
        rea_sum_next = rea_sum_reg
                     - {{(SUM_W-PROD_W){rea_old[PROD_W-1]}}, rea_old}
                     + {{(SUM_W-PROD_W){rea_new[PROD_W-1]}}, rea_new};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_pos_reg <= '0;
            fill_reg    <= '0;
            act_sum_reg <= '0;
            rea_sum_reg <= '0;
        end
        else
        begin
            win_pos_reg <= win_pos_next;
            if (ring_upd)
            begin
                act_sum_reg <= act_sum_next;
                rea_sum_reg <= rea_sum_next;
                if (!win_full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_upd)
        begin
            s3_apparent_reg <= sat32(s2_app_prod_reg >>> FRAC_BITS);
            s3_full_reg     <= full_after;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: window means. The sums stay put while stage 3 holds its
    // sample, so the mean units read them directly.
    // ------------------------------------------------------------------
    logic                     mean_load;
    logic signed [DATA_W-1:0] act_mean, rea_mean;
    logic signed [DATA_W-1:0] s4_apparent_reg;
    logic                     s4_full_reg;

    assign mean_load = s3_valid_reg && s4_free;

    apm_mean #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_act_mean (
        .clk  (clk),
        .load (mean_load),
        .sum  (act_sum_reg),
        .mean (act_mean)
    );

    apm_mean #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_rea_mean (
        .clk  (clk),
        .load (mean_load),
        .sum  (rea_sum_reg),
        .mean (rea_mean)
    );

    always_ff @(posedge clk)
    begin
        if (mean_load)
        begin
            s4_apparent_reg <= s3_apparent_reg;
            s4_full_reg     <= s3_full_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds a result until its transfer.
    // ------------------------------------------------------------------
    result_t result_reg;

    always_ff @(posedge clk)
    begin
        if (s4_valid_reg && out_free)
        begin
            result_reg.apparent_power <= s4_apparent_reg;
            result_reg.active_power   <= act_mean;
            result_reg.reactive_power <= rea_mean;
            result_reg.valid_res      <= s4_full_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

>>> design/apm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module apm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/apm_mean.sv
// Window mean of a running sum, one register stage, then saturation to 32 bits.
module apm_mean #(
    parameter int WINDOW_LEN = apm_pkg::DEF_WINDOW_LEN,
    localparam int SUM_W = apm_pkg::PROD_W + $clog2(WINDOW_LEN)
) (
    input  logic                            clk,
    input  logic                            load,
    input  logic signed [SUM_W-1:0]         sum,
    output logic signed [apm_pkg::DATA_W-1:0] mean
);

    import apm_pkg::*;

    localparam int LG_WIN = $clog2(WINDOW_LEN);

    generate
        if ((WINDOW_LEN & (WINDOW_LEN - 1)) == 0)
        begin : g_shift
            // Power-of-two window: the mean is a plain arithmetic shift.
            localparam int SH_W = SUM_W - LG_WIN;
            logic signed [SH_W-1:0] shifted_reg;

            always_ff @(posedge clk)
            begin
                if (load)
                begin
                    shifted_reg <= sum[SUM_W-1:LG_WIN];
                end
            end

            assign mean = sat32({{(64-SH_W){shifted_reg[SH_W-1]}}, shifted_reg});
        end
        else
        begin : g_recip
            // Other windows: multiply by the Q24 reciprocal, split in two halves
            // so that each multiplier stays narrow.
            localparam int RECIP_W = FRAC_BITS + 1;
            localparam int RECIP_I = (1 << FRAC_BITS) / WINDOW_LEN;
            localparam logic signed [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_I);
            localparam int LO_W   = SUM_W / 2;
            localparam int HI_W   = SUM_W - LO_W;
            localparam int HP_W   = HI_W + RECIP_W;
            localparam int LP_W   = LO_W + 1 + RECIP_W;
            localparam int FULL_W = SUM_W + RECIP_W + 1;
            localparam int SC_W   = FULL_W - FRAC_BITS;

            logic signed [HP_W-1:0]   hi_prod_reg;
            logic signed [LP_W-1:0]   lo_prod_reg;
            logic signed [FULL_W-1:0] full;
            logic signed [SC_W-1:0]   scaled;

            always_ff @(posedge clk)
            begin
                if (load)
                begin
                    hi_prod_reg <= $signed(sum[SUM_W-1:LO_W]) * RECIP;
                    lo_prod_reg <= $signed({1'b0, sum[LO_W-1:0]}) * RECIP;
                end
            end

            always_comb
            begin
                full = {{(FULL_W-HP_W-LO_W){hi_prod_reg[HP_W-1]}}, hi_prod_reg, {LO_W{1'b0}}}
                     + {{(FULL_W-LP_W){lo_prod_reg[LP_W-1]}}, lo_prod_reg};
                scaled = full[FULL_W-1:FRAC_BITS];
            end

            assign mean = sat32({{(64-SC_W){scaled[SC_W-1]}}, scaled});
        end
    endgenerate

endmodule

>>> design/apm_checker.sv
// Port-level checker of the AC power meter, bound to the top level.
`include "ac_power_meter_unit_macros.svh"

module apm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_ready,
    input logic             result_valid,
    input logic             result_ready,
    input apm_pkg::result_t result,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic             cfg_data
);

    import apm_pkg::*;

    // Shadow of the enable bit, count of enabled samples still owed a result,
    // and whether a result with the window filled has been transferred.
    logic       enable_reg;
    logic [3:0] inflight_reg;
    logic       seen_full_reg;
    logic       inc, dec;

    assign inc = sample_valid && sample_ready && enable_reg;
    assign dec = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            inflight_reg  <= '0;
            seen_full_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                enable_reg <= cfg_data;
            end
            inflight_reg <= inflight_reg + {3'b000, inc} - {3'b000, dec};
            if (dec && result.valid_res)
            begin
                seen_full_reg <= 1'b1;
            end
        end
    end

    `APM_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")
    `APM_ASSERT_SAME(a_no_spurious_result, result_valid, inflight_reg != 4'd0, "result without an enabled sample")
    `APM_ASSERT_SAME(a_ready_when_drained, !result_valid, sample_ready, "sample not taken with empty output")
    `APM_ASSERT_SAME(a_valid_res_sticky, seen_full_reg && result_valid, result.valid_res, "valid_res dropped after window filled")

endmodule

bind ac_power_meter_unit apm_checker u_apm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
);
